/* sv/owtsd_pkg.sv */
package owtsd_pkg;

   localparam int BYTE_W = 8;
   localparam int STORE_DEPTH = 8;
   localparam int INDEX_W = 4;
   localparam int BIT_CNT_W = $clog2(BYTE_W);
   localparam int TEMP_W = 25;
   localparam int STATUS_W = 2;
   localparam int RAW_W = 16;
   localparam int PROD_W = 26;
   localparam int DIFF_W = BYTE_W + 1;
   localparam int NUM_W = 18;
   localparam int DIV_CNT_W = $clog2(NUM_W);

   localparam int MILLI_VALUE = 1000;
   localparam int QUARTER_MILLI_VALUE = 250;
   localparam int SIXTEENTHS_VALUE = 16;
   localparam int SIXTEENTH_SHIFT = $clog2(SIXTEENTHS_VALUE);

   localparam logic signed [PROD_W-1:0] MILLI = PROD_W'(MILLI_VALUE);
   localparam logic signed [PROD_W-1:0] QUARTER_MILLI = PROD_W'(QUARTER_MILLI_VALUE);
   localparam logic signed [PROD_W-1:0] SIXTEENTH_BIAS = PROD_W'(SIXTEENTHS_VALUE - 1);

   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(STORE_DEPTH);
   localparam logic [BYTE_W-1:0] FAMILY_EXTENDED = 8'h10;
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CRC_ERR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_COUNT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CRC,
      ST_CALC,
      ST_DIV,
      ST_FIN
   } owtsd_state_type;

   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  dividend;
      logic [BYTE_W-1:0] divisor;
   } owtsd_div_req_type;

endpackage

/* sv/owtsd_div.sv */
module owtsd_div (
   input  logic                              clock,
   input  logic                              reset,
   input  owtsd_pkg::owtsd_div_req_type      div_req,
   output logic                              div_done,
   output logic [owtsd_pkg::NUM_W-1:0]       div_quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [owtsd_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [owtsd_pkg::BYTE_W-1:0]       rem_ff, rem_in;
   logic [owtsd_pkg::BYTE_W-1:0]       den_ff, den_in;
   logic [owtsd_pkg::NUM_W-1:0]        quo_ff, quo_in;
   logic [owtsd_pkg::BYTE_W:0]         trial;
   logic [owtsd_pkg::BYTE_W:0]         trial_sub;
   logic                               trial_ge;

   assign trial     = {rem_ff, quo_ff[owtsd_pkg::NUM_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign trial_ge  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         rem_in = trial_ge ? trial_sub[owtsd_pkg::BYTE_W-1:0] : trial[owtsd_pkg::BYTE_W-1:0];
         quo_in = {quo_ff[owtsd_pkg::NUM_W-2:0], trial_ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == owtsd_pkg::DIV_CNT_W'(owtsd_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_done     = done_ff;
   assign div_quotient = quo_ff;

endmodule

/* sv/onewire_temp_scratchpad_decode.sv */
// Scratchpad decoder for 1-Wire temperature sensors.
// Input channel req_: one scratchpad byte per item in bus order, bytes 0 to 8,
// with the sensor family code on req_tuser (used with byte 8 only).
// Result channel rsp_: one item per nine-byte frame, temperature in thousandths
// of a degree on rsp_tdata and status (ok, CRC error, zero count fallback) on
// rsp_tuser.
// Bytes 0 to 7 are each accepted and then run through a bit-serial CRC-8
// shifter in ST_CRC; req_tready is low meanwhile.
// Byte 8 passes from ST_CALC to ST_FIN, where the result is loaded, on the
// 9- to 12-bit, fallback and CRC error paths; on the extended-resolution path
// it waits in ST_DIV for the 18-step bit-serial divider that forms the
// count-per-degree fraction. The block holds one item in flight at a time.
// Reset clears the byte index, the CRC and the result valid; the next byte
// accepted is byte 0 of a frame.
// The result sits in an output register: bytes of the next frame are taken
// while it waits, and only the finish of the next frame holds until the
// receiver takes it.
module onewire_temp_scratchpad_decode (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scratch_byte
   input  logic [7:0]  req_tuser,   // [7:0] family_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [24:0] temp_milli, [31:25] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   owtsd_pkg::owtsd_state_type                  state_ff, state_in;
   logic [owtsd_pkg::INDEX_W-1:0]               idx_ff, idx_in;
   logic [owtsd_pkg::BYTE_W-1:0]                crc_ff, crc_in;
   logic [owtsd_pkg::BYTE_W-1:0]                sh_ff, sh_in;
   logic [owtsd_pkg::BIT_CNT_W-1:0]             bit_ff, bit_in;
   logic [owtsd_pkg::BYTE_W-1:0]                store_ff [owtsd_pkg::STORE_DEPTH];
   logic [owtsd_pkg::BYTE_W-1:0]                store_in [owtsd_pkg::STORE_DEPTH];
   logic                                        store_en;
   logic                                        crc_bad_ff, crc_bad_in;
   logic                                        ext_ff, ext_in;
   logic                                        neg_ff, neg_in;
   logic signed [owtsd_pkg::PROD_W-1:0]         base_ff, base_in;
   logic signed [owtsd_pkg::TEMP_W-1:0]         temp_ff, temp_in;
   logic [owtsd_pkg::STATUS_W-1:0]              status_ff, status_in;
   logic                                        rsp_valid_ff;
   logic signed [owtsd_pkg::TEMP_W-1:0]         rsp_temp_ff;
   logic [owtsd_pkg::STATUS_W-1:0]              rsp_status_ff;
   logic                                        rsp_load;
   logic                                        req_accept;
   logic                                        crc_fb;

   logic [owtsd_pkg::RAW_W-1:0]                 raw;
   logic [1:0]                                  drop;
   logic [owtsd_pkg::RAW_W-1:0]                 keep_mask;
   logic [owtsd_pkg::RAW_W-1:0]                 sel;
   logic signed [owtsd_pkg::PROD_W-1:0]         sel_ext;
   logic signed [owtsd_pkg::PROD_W-1:0]         prod;
   logic signed [owtsd_pkg::PROD_W-1:0]         bias16;
   logic signed [owtsd_pkg::PROD_W-1:0]         temp16;
   logic signed [owtsd_pkg::PROD_W-1:0]         temp_half;
   logic signed [owtsd_pkg::PROD_W-1:0]         s15_ext;
   logic signed [owtsd_pkg::PROD_W-1:0]         ext_base;
   logic [owtsd_pkg::DIFF_W-1:0]                diff;
   logic [owtsd_pkg::DIFF_W-1:0]                diff_abs;
   logic signed [owtsd_pkg::PROD_W-1:0]         quo_ext;
   logic signed [owtsd_pkg::PROD_W-1:0]         temp_ext;

   owtsd_pkg::owtsd_div_req_type                div_req;
   logic                                        div_done;
   logic [owtsd_pkg::NUM_W-1:0]                 div_quotient;

   owtsd_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_req      (div_req),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   assign req_tready = (state_ff == owtsd_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign crc_fb     = crc_ff[0] ^ sh_ff[0];

   assign raw       = {store_ff[1], store_ff[0]};
   assign drop      = 2'd3 - store_ff[4][6:5];
   assign keep_mask = {owtsd_pkg::RAW_W{1'b1}} << drop;
   assign sel       = ext_ff ? raw : (raw & keep_mask);
   assign sel_ext   = {{(owtsd_pkg::PROD_W - owtsd_pkg::RAW_W){sel[owtsd_pkg::RAW_W-1]}}, sel};
   assign prod      = sel_ext * owtsd_pkg::MILLI;
   assign bias16    = prod[owtsd_pkg::PROD_W-1] ? owtsd_pkg::SIXTEENTH_BIAS : '0;
   assign temp16    = (prod + bias16) >>> owtsd_pkg::SIXTEENTH_SHIFT;
   assign temp_half = prod >>> 1;
   assign s15_ext   = {{(owtsd_pkg::PROD_W - owtsd_pkg::RAW_W + 1){raw[owtsd_pkg::RAW_W-1]}},
                       raw[owtsd_pkg::RAW_W-1:1]};
   assign ext_base  = s15_ext * owtsd_pkg::MILLI - owtsd_pkg::QUARTER_MILLI;
   assign diff      = {1'b0, store_ff[7]} - {1'b0, store_ff[6]};
   assign diff_abs  = diff[owtsd_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
   assign quo_ext   = owtsd_pkg::PROD_W'(div_quotient);
   assign temp_ext  = base_ff + (neg_ff ? -quo_ext : quo_ext);

   always_comb begin
      for (int i = 0; i < owtsd_pkg::STORE_DEPTH - 1; i++) begin
         store_in[i] = store_ff[i+1];
      end
      store_in[owtsd_pkg::STORE_DEPTH-1] = req_tdata;
   end

   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      crc_in           = crc_ff;
      sh_in            = sh_ff;
      bit_in           = bit_ff;
      store_en         = 1'b0;
      crc_bad_in       = crc_bad_ff;
      ext_in           = ext_ff;
      neg_in           = neg_ff;
      base_in          = base_ff;
      temp_in          = temp_ff;
      status_in        = status_ff;
      rsp_load         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = owtsd_pkg::NUM_W'(diff_abs[owtsd_pkg::BYTE_W-1:0])
                         * owtsd_pkg::NUM_W'(owtsd_pkg::MILLI_VALUE);
      div_req.divisor  = store_ff[7];
      case (state_ff)
         owtsd_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (idx_ff == owtsd_pkg::LAST_INDEX) begin
                  crc_bad_in = (crc_ff != req_tdata);
                  ext_in     = (req_tuser == owtsd_pkg::FAMILY_EXTENDED);
                  state_in   = owtsd_pkg::ST_CALC;
               end else begin
                  sh_in    = req_tdata;
                  bit_in   = '0;
                  store_en = 1'b1;
                  idx_in   = idx_ff + 1'b1;
                  state_in = owtsd_pkg::ST_CRC;
               end
            end
         end
         owtsd_pkg::ST_CRC: begin
            crc_in = {1'b0, crc_ff[owtsd_pkg::BYTE_W-1:1]} ^ (crc_fb ? owtsd_pkg::CRC_POLY : '0);
            sh_in  = {1'b0, sh_ff[owtsd_pkg::BYTE_W-1:1]};
            bit_in = bit_ff + 1'b1;
            if (bit_ff == owtsd_pkg::BIT_CNT_W'(owtsd_pkg::BYTE_W - 1)) begin
               state_in = owtsd_pkg::ST_IDLE;
            end
         end
         owtsd_pkg::ST_CALC: begin
            if (crc_bad_ff) begin
               temp_in   = '0;
               status_in = owtsd_pkg::STATUS_CRC_ERR;
               state_in  = owtsd_pkg::ST_FIN;
            end else if (!ext_ff) begin
               temp_in   = temp16[owtsd_pkg::TEMP_W-1:0];
               status_in = owtsd_pkg::STATUS_OK;
               state_in  = owtsd_pkg::ST_FIN;
            end else if (store_ff[7] == '0) begin
               temp_in   = temp_half[owtsd_pkg::TEMP_W-1:0];
               status_in = owtsd_pkg::STATUS_NO_COUNT;
               state_in  = owtsd_pkg::ST_FIN;
            end else begin
               div_req.start = 1'b1;
               base_in       = ext_base;
               neg_in        = diff[owtsd_pkg::DIFF_W-1];
               status_in     = owtsd_pkg::STATUS_OK;
               state_in      = owtsd_pkg::ST_DIV;
            end
         end
         owtsd_pkg::ST_DIV: begin
            if (div_done) begin
               temp_in  = temp_ext[owtsd_pkg::TEMP_W-1:0];
               state_in = owtsd_pkg::ST_FIN;
            end
         end
         owtsd_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               idx_in   = '0;
               crc_in   = '0;
               state_in = owtsd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = owtsd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= owtsd_pkg::ST_IDLE;
         idx_ff       <= '0;
         crc_ff       <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         crc_ff   <= crc_in;
         bit_ff   <= bit_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sh_ff      <= sh_in;
      crc_bad_ff <= crc_bad_in;
      ext_ff     <= ext_in;
      neg_ff     <= neg_in;
      base_ff    <= base_in;
      temp_ff    <= temp_in;
      status_ff  <= status_in;
      if (store_en) begin
         store_ff <= store_in;
      end
      if (rsp_load) begin
         rsp_temp_ff   <= temp_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32 - owtsd_pkg::TEMP_W){1'b0}}, rsp_temp_ff};
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= owtsd_pkg::LAST_INDEX)
      else $error("byte index past end of frame");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == owtsd_pkg::ST_FIN))
      else $error("result raised outside finish state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == owtsd_pkg::ST_DIV))
      else $error("divider finished while not awaited");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == owtsd_pkg::STATUS_OK
                        || rsp_status_ff == owtsd_pkg::STATUS_CRC_ERR
                        || rsp_status_ff == owtsd_pkg::STATUS_NO_COUNT))
      else $error("undefined status on result");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (idx_ff == '0 && crc_ff == '0 && rsp_valid_ff))
      else $error("frame state not cleared after result");
`endif

endmodule
